// File: rtl/core/sed_pkg.sv
// shared types, widths and register codes for the symmetric epipolar distance block
package sed_pkg;

  localparam int COORD_W = 24;                     // Q8.16 point coordinates
  localparam int COEF_W  = 21;                     // Q4.17 matrix entries
  localparam int ROW_W   = 63;                     // stored matrix row width
  localparam int ALIGN   = 16;                     // shift that lines up constant terms
  localparam int PROD_W  = COORD_W + COEF_W;       // one coefficient product
  localparam int LINE_W  = PROD_W + 2;             // exact line coefficient
  localparam int MAG_W   = 30;                     // normalized coefficient magnitude
  localparam int NUM_W   = COORD_W + MAG_W + 3;    // line equation value
  localparam int SQ_W    = 2 * MAG_W + 2;          // sum of squares and root register
  localparam int SQRT_N  = SQ_W / 2;               // root cells, one per root bit
  localparam int DEN_W   = MAG_W + 1;              // root width
  localparam int Q_W     = 34;                     // quotient bits kept
  localparam int REM_W   = (NUM_W + 1 > DEN_W + Q_W - 1) ? NUM_W + 1 : DEN_W + Q_W - 1;
  localparam int DIST_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 64;

  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] ref_u;
    logic signed [COORD_W-1:0] ref_v;
    logic signed [COORD_W-1:0] cur_u;
    logic signed [COORD_W-1:0] cur_v;
  } in_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] forward_distance;
    logic signed [DIST_W-1:0] backward_distance;
    logic                     forward_degenerate;
    logic                     backward_degenerate;
  } out_t;

endpackage

// File: rtl/core/symmetric_epipolar_distance_top.sv
// Symmetric epipolar distance: one point pair per clock while the output is not stalled. A
// request passes the matrix products and line coefficients, line normalization and
// evaluation, a 31-cell square root row, a 34-cell divide row with rounding setup,
// a saturation stage and the output register. The forward and backward lines run in
// two identical units side by side. A stalled output holds the whole pipe, so in_ready_o
// follows out_ready_i while a result waits. Matrix rows sit at byte addresses 0, 8, 16
// and may be written only while no request is in flight.
module symmetric_epipolar_distance_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sed_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sed_pkg::out_t                 out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sed_pkg::ADDR_W-1:0]    paddr,
  input  logic [sed_pkg::DATA_W-1:0]    pwdata,
  output logic [sed_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import sed_pkg::*;

  logic [ROW_W-1:0] mat_q [3];
  logic             en;
  logic             out_valid_q;
  out_t             out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign pready     = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= '0;
      mat_q[1] <= '0;
      mat_q[2] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[4:3]))
        REG_ROW0: mat_q[0] <= pwdata[ROW_W-1:0];
        REG_ROW1: mat_q[1] <= pwdata[ROW_W-1:0];
        REG_ROW2: mat_q[2] <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:3]))
      REG_ROW0: prdata = DATA_W'(mat_q[0]);
      REG_ROW1: prdata = DATA_W'(mat_q[1]);
      REG_ROW2: prdata = DATA_W'(mat_q[2]);
      default:  prdata = '0;
    endcase
  end

  logic signed [COEF_W-1:0] e [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e[r][c] = $signed(mat_q[r][c*COEF_W +: COEF_W]);
      end
    end
  end

  // stage 1: coefficient products and their sums into line coefficients, line 0 forward, line 1 backward
  logic                      v1_q, v2_q;
  logic signed [PROD_W-1:0]  prod_q [2][3][3];
  in_t                       pt1_q, pt2_q;
  logic signed [LINE_W-1:0]  abc_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[0][r][0] <= e[r][0] * in_data_i.ref_u;
        prod_q[0][r][1] <= e[r][1] * in_data_i.ref_v;
        prod_q[0][r][2] <= PROD_W'(e[r][2]) <<< ALIGN;
        prod_q[1][r][0] <= e[0][r] * in_data_i.cur_u;
        prod_q[1][r][1] <= e[1][r] * in_data_i.cur_v;
        prod_q[1][r][2] <= PROD_W'(e[2][r]) <<< ALIGN;
      end
      pt1_q <= in_data_i;
      for (int l = 0; l < 2; l++) begin
        for (int r = 0; r < 3; r++) begin
          abc_q[l][r] <= LINE_W'(prod_q[l][r][0]) + LINE_W'(prod_q[l][r][1])
                       + LINE_W'(prod_q[l][r][2]);
        end
      end
      pt2_q <= pt1_q;
    end
  end

  logic                     fv, bv, fdg, bdg;
  logic signed [DIST_W-1:0] fd, bd;

  sed_line u_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v2_q),
    .a_i    (abc_q[0][0]),
    .b_i    (abc_q[0][1]),
    .c_i    (abc_q[0][2]),
    .x_i    (pt2_q.cur_u),
    .y_i    (pt2_q.cur_v),
    .valid_o(fv),
    .dist_o (fd),
    .degen_o(fdg)
  );

  sed_line u_bwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v2_q),
    .a_i    (abc_q[1][0]),
    .b_i    (abc_q[1][1]),
    .c_i    (abc_q[1][2]),
    .x_i    (pt2_q.ref_u),
    .y_i    (pt2_q.ref_v),
    .valid_o(bv),
    .dist_o (bd),
    .degen_o(bdg)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fv && bv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.forward_distance    <= fd;
      out_q.backward_distance   <= bd;
      out_q.forward_degenerate  <= fdg;
      out_q.backward_degenerate <= bdg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/sed_sqrt_cell.sv
// one cell of the square root row: settles one root bit
module sed_sqrt_cell #(
  parameter int W       = 62,
  parameter int BIT_POS = 0,
  parameter int SIDE_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [W-1:0]      s_i,
  input  logic [W-1:0]      res_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [W-1:0]      s_o,
  output logic [W-1:0]      res_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [W-1:0] BitVal = W'(1) << BIT_POS;

  logic              valid_q;
  logic [W-1:0]      s_d, s_q, res_d, res_q, trial;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    trial = res_i + BitVal;
    if (s_i >= trial) begin
      s_d   = s_i - trial;
      res_d = (res_i >> 1) + BitVal;
    end else begin
      s_d   = s_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign res_o   = res_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/sed_div_cell.sv
// one cell of the divide row: settles one quotient bit
module sed_div_cell #(
  parameter int RW     = 64,
  parameter int DW     = 31,
  parameter int QW     = 34,
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RW-1:0]     rem_i,
  input  logic [DW-1:0]     den_i,
  input  logic [QW-1:0]     q_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RW-1:0]     rem_o,
  output logic [DW-1:0]     den_o,
  output logic [QW-1:0]     q_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q, qbit;
  logic [RW-1:0]     dsh, rem_d, rem_q;
  logic [DW-1:0]     den_q;
  logic [QW-1:0]     q_q;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    dsh   = RW'(den_i) << SHIFT;
    qbit  = (rem_i >= dsh);
    rem_d = qbit ? rem_i - dsh : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      q_q    <= {q_i[QW-2:0], qbit};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/sed_line.sv
// distance of one point to one line: normalize, evaluate, root row, divide row
module sed_line (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [sed_pkg::LINE_W-1:0]  a_i,
  input  logic signed [sed_pkg::LINE_W-1:0]  b_i,
  input  logic signed [sed_pkg::LINE_W-1:0]  c_i,
  input  logic signed [sed_pkg::COORD_W-1:0] x_i,
  input  logic signed [sed_pkg::COORD_W-1:0] y_i,
  output logic                               valid_o,
  output logic signed [sed_pkg::DIST_W-1:0]  dist_o,
  output logic                               degen_o
);
  import sed_pkg::*;

  localparam int SH_W   = $clog2(LINE_W);
  localparam int PA_W   = MAG_W + 1 + COORD_W;
  localparam int PC_W   = MAG_W + 1 + ALIGN;
  localparam int SSIDE  = NUM_W + 2;
  localparam logic [SH_W-1:0] TopPos = SH_W'(MAG_W - 1);
  localparam logic [Q_W-1:0] PosLim = Q_W'(33'h0_7FFF_FFFF);
  localparam logic [Q_W-1:0] NegLim = Q_W'(33'h0_8000_0000);

  // stage 1: magnitudes and their maximum
  logic [4:0]               v_q;
  logic [LINE_W-1:0]        am1_d, bm1_d, cm1_d, m1_d;
  logic [LINE_W-1:0]        am1_q, bm1_q, cm1_q, m1_q;
  logic [2:0]               sg1_q;
  logic                     dg1_q;
  logic signed [COORD_W-1:0] x1_q, y1_q;

  always_comb begin
    am1_d = LINE_W'(a_i[LINE_W-1] ? -a_i : a_i);
    bm1_d = LINE_W'(b_i[LINE_W-1] ? -b_i : b_i);
    cm1_d = LINE_W'(c_i[LINE_W-1] ? -c_i : c_i);
    m1_d  = (bm1_d > am1_d) ? bm1_d : am1_d;
    m1_d  = (cm1_d > m1_d) ? cm1_d : m1_d;
  end

  // stage 2: leading one position gives the scale
  logic [SH_W-1:0]          p2;
  logic [LINE_W-1:0]        am2_q, bm2_q, cm2_q;
  logic [2:0]               sg2_q;
  logic                     dg2_q, shr2_q;
  logic [SH_W-1:0]          amt2_q;
  logic signed [COORD_W-1:0] x2_q, y2_q;

  always_comb begin
    p2 = '0;
    for (int i = 0; i < LINE_W; i++) begin
      if (m1_q[i]) p2 = SH_W'(i);
    end
  end

  // stage 3: apply the scale, rebuild signed values
  logic [MAG_W-1:0]          an3, bn3, cn3, am3_q, bm3_q;
  logic signed [MAG_W:0]     sa3_q, sb3_q, sc3_q;
  logic                      dg3_q;
  logic signed [COORD_W-1:0] x3_q, y3_q;

  always_comb begin
    an3 = MAG_W'(shr2_q ? am2_q >> amt2_q : am2_q << amt2_q);
    bn3 = MAG_W'(shr2_q ? bm2_q >> amt2_q : bm2_q << amt2_q);
    cn3 = MAG_W'(shr2_q ? cm2_q >> amt2_q : cm2_q << amt2_q);
  end

  // stage 4: products
  logic signed [PA_W-1:0]   pa4_q, pb4_q;
  logic signed [PC_W-1:0]   pc4_q;
  logic [2*MAG_W-1:0]       a24_q, b24_q;
  logic                     dg4_q;

  // stage 5: line value and sum of squares
  logic signed [NUM_W-1:0]  num5;
  logic [NUM_W-1:0]         an5_q;
  logic                     neg5_q, dg5_q;
  logic [SQ_W-1:0]          s5_q;

  always_comb begin
    num5 = NUM_W'(pa4_q) + NUM_W'(pb4_q) + NUM_W'(pc4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am1_q  <= am1_d;
      bm1_q  <= bm1_d;
      cm1_q  <= cm1_d;
      m1_q   <= m1_d;
      sg1_q  <= {c_i[LINE_W-1], b_i[LINE_W-1], a_i[LINE_W-1]};
      dg1_q  <= (a_i == '0) && (b_i == '0);
      x1_q   <= x_i;
      y1_q   <= y_i;

      am2_q  <= am1_q;
      bm2_q  <= bm1_q;
      cm2_q  <= cm1_q;
      sg2_q  <= sg1_q;
      dg2_q  <= dg1_q;
      shr2_q <= (p2 >= TopPos);
      amt2_q <= (p2 >= TopPos) ? p2 - TopPos : TopPos - p2;
      x2_q   <= x1_q;
      y2_q   <= y1_q;

      am3_q  <= an3;
      bm3_q  <= bn3;
      sa3_q  <= sg2_q[0] ? -$signed({1'b0, an3}) : $signed({1'b0, an3});
      sb3_q  <= sg2_q[1] ? -$signed({1'b0, bn3}) : $signed({1'b0, bn3});
      sc3_q  <= sg2_q[2] ? -$signed({1'b0, cn3}) : $signed({1'b0, cn3});
      dg3_q  <= dg2_q;
      x3_q   <= x2_q;
      y3_q   <= y2_q;

      pa4_q  <= sa3_q * x3_q;
      pb4_q  <= sb3_q * y3_q;
      pc4_q  <= PC_W'(sc3_q) <<< ALIGN;
      a24_q  <= am3_q * am3_q;
      b24_q  <= bm3_q * bm3_q;
      dg4_q  <= dg3_q;

      an5_q  <= NUM_W'(num5[NUM_W-1] ? -num5 : num5);
      neg5_q <= num5[NUM_W-1];
      s5_q   <= SQ_W'(a24_q) + SQ_W'(b24_q);
      dg5_q  <= dg4_q;
    end
  end

  // square root row
  logic             sq_v    [SQRT_N+1];
  logic [SQ_W-1:0]  sq_s    [SQRT_N+1];
  logic [SQ_W-1:0]  sq_r    [SQRT_N+1];
  logic [SSIDE-1:0] sq_side [SQRT_N+1];

  assign sq_v[0]    = v_q[4];
  assign sq_s[0]    = s5_q;
  assign sq_r[0]    = '0;
  assign sq_side[0] = {dg5_q, neg5_q, an5_q};

  for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
    sed_sqrt_cell #(
      .W      (SQ_W),
      .BIT_POS(2 * (SQRT_N - 1 - i)),
      .SIDE_W (SSIDE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(sq_v[i]),
      .s_i    (sq_s[i]),
      .res_i  (sq_r[i]),
      .side_i (sq_side[i]),
      .valid_o(sq_v[i+1]),
      .s_o    (sq_s[i+1]),
      .res_o  (sq_r[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // stage 6: dividend with half the divisor added for rounding
  logic [DEN_W-1:0] den6;
  logic [REM_W-1:0] rem6_q;
  logic [DEN_W-1:0] den6_q;
  logic [1:0]       side6_q;
  logic             v6_q;

  assign den6 = sq_r[SQRT_N][DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en_i) begin
      v6_q <= sq_v[SQRT_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem6_q  <= REM_W'(sq_side[SQRT_N][NUM_W-1:0]) + REM_W'(den6 >> 1);
      den6_q  <= den6;
      side6_q <= sq_side[SQRT_N][NUM_W+1:NUM_W];
    end
  end

  // divide row, quotient msb first
  logic             dv_v    [Q_W+1];
  logic [REM_W-1:0] dv_rem  [Q_W+1];
  logic [DEN_W-1:0] dv_den  [Q_W+1];
  logic [Q_W-1:0]   dv_q    [Q_W+1];
  logic [1:0]       dv_side [Q_W+1];

  assign dv_v[0]    = v6_q;
  assign dv_rem[0]  = rem6_q;
  assign dv_den[0]  = den6_q;
  assign dv_q[0]    = '0;
  assign dv_side[0] = side6_q;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    sed_div_cell #(
      .RW    (REM_W),
      .DW    (DEN_W),
      .QW    (Q_W),
      .SHIFT (Q_W - 1 - i),
      .SIDE_W(2)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(dv_v[i]),
      .rem_i  (dv_rem[i]),
      .den_i  (dv_den[i]),
      .q_i    (dv_q[i]),
      .side_i (dv_side[i]),
      .valid_o(dv_v[i+1]),
      .rem_o  (dv_rem[i+1]),
      .den_o  (dv_den[i+1]),
      .q_o    (dv_q[i+1]),
      .side_o (dv_side[i+1])
    );
  end

  // stage 7: sign, saturation, degenerate line
  logic [Q_W-1:0]           qf;
  logic                     negf, dgf, v7_q, dg7_q;
  logic signed [DIST_W-1:0] dist7_d, dist7_q;

  always_comb begin
    qf   = dv_q[Q_W];
    negf = dv_side[Q_W][0];
    dgf  = dv_side[Q_W][1];
    if (dgf) begin
      dist7_d = '0;
    end else if (negf) begin
      dist7_d = (qf > NegLim) ? DIST_W'(32'h8000_0000) : -$signed(qf[DIST_W-1:0]);
    end else begin
      dist7_d = (qf > PosLim) ? DIST_W'(32'h7FFF_FFFF) : $signed(qf[DIST_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en_i) begin
      v7_q <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist7_q <= dist7_d;
      dg7_q   <= dgf;
    end
  end

  assign valid_o = v7_q;
  assign dist_o  = dist7_q;
  assign degen_o = dg7_q;

endmodule
